// File: design/fcdm_pkg.sv
// ----------------------------------------------------------------------------
// fcdm_pkg
// Shared types and constants for the chain directory manager.
// ----------------------------------------------------------------------------
package fcdm_pkg;

    localparam int DIR_SLOTS_DEF    = 256;
    localparam int TABLE_BLOCKS_DEF = 1024;

    localparam int BLOCK_BYTES      = 4096;
    localparam int NAME_W           = 48;
    localparam int NAME_CHARS       = 6;
    localparam int LEN_W            = 23;
    localparam int DISK_W           = 11;
    localparam int FIRST_W          = 10;
    localparam int CFG_INDEX_W      = 1;
    localparam int FIRST_DATA_BLOCK = 3;
    localparam int LENGTH_MAX       = 4194304;

    localparam logic [2:0] REQ_FORMAT = 3'd0;
    localparam logic [2:0] REQ_CREATE = 3'd1;
    localparam logic [2:0] REQ_DELETE = 3'd2;
    localparam logic [2:0] REQ_SIZE   = 3'd3;
    localparam logic [2:0] REQ_GROW   = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ERR       = 3'd1;
    localparam logic [2:0] ST_DIR_FULL  = 3'd2;
    localparam logic [2:0] ST_DISK_FULL = 3'd3;
    localparam logic [2:0] ST_PARTIAL   = 3'd4;

    localparam logic [CFG_INDEX_W-1:0] CFG_DISK_BLOCKS = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MOUNTED     = 1'd1;

    typedef struct packed {
        logic [2:0]        req_type;
        logic [NAME_W-1:0] file_name;
        logic [LEN_W-1:0]  add_bytes;
    } req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [LEN_W-1:0]   file_size;
        logic [LEN_W-1:0]   bytes_added;
        logic [FIRST_W-1:0] first_block;
    } rsp_t;

endpackage

// File: design/fat_chain_directory_manager_top.sv
// ----------------------------------------------------------------------------
// fat_chain_directory_manager_top
// Directory of named files over a block-link table, one request at a time.
// ----------------------------------------------------------------------------
// One request is taken at a time and gives one result beat. Directory and
// link table live in RAMs with registered reads, so every probe takes a
// read state and a check state: a lookup probes each directory slot up to
// the match, a chain walk each link, a free-block search each table entry
// passed, and create scans slot flags one slot per cycle. Format rewrites
// the table entries up to the disk size, one block per cycle. After reset
// the whole table is initialized while req_stall is high.
module fat_chain_directory_manager_top #(
    parameter int DIR_SLOTS    = fcdm_pkg::DIR_SLOTS_DEF,
    parameter int TABLE_BLOCKS = fcdm_pkg::TABLE_BLOCKS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fcdm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fcdm_pkg::DISK_W-1:0]         cfg_data,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  fcdm_pkg::req_t                      req,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output fcdm_pkg::rsp_t                      rsp
);
    import fcdm_pkg::*;

    localparam int SLOT_W = (DIR_SLOTS > 1) ? $clog2(DIR_SLOTS) : 1;
    localparam int SCNT_W = $clog2(DIR_SLOTS + 1);
    localparam int BLK_W  = $clog2(TABLE_BLOCKS);
    localparam int BCNT_W = $clog2(TABLE_BLOCKS + 1);
    localparam int ACT_W  = (BCNT_W > DISK_W) ? BCNT_W : DISK_W;

    typedef struct packed {
        logic [NAME_W-1:0] name;
        logic [LEN_W-1:0]  len;
        logic [BLK_W-1:0]  first;
    } dir_t;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SLOT_FREE, S_FREE_RD, S_FREE_CHK, S_GROW_END,
        S_FIND_RD, S_FIND_CHK, S_WALK_RD, S_WALK_CHK, S_GROW_START,
        S_GROW_FIN, S_DONE
    } state_t;

    localparam logic [BLK_W-1:0] LINK_FREE = BLK_W'(0);
    localparam logic [BLK_W-1:0] LINK_END  = BLK_W'(1);
    localparam logic [LEN_W-1:0] BB        = LEN_W'(BLOCK_BYTES);
    localparam logic [LEN_W-1:0] LMAX      = LEN_W'(LENGTH_MAX);

    state_t                 state_reg;
    logic                   fmt_reg;
    logic [2:0]             op_reg;
    logic [NAME_W-1:0]      name_reg;
    logic [LEN_W-1:0]       add_reg;
    logic [DISK_W-1:0]      disk_blocks_reg;
    logic                   mounted_reg;
    logic [DIR_SLOTS-1:0]   used_reg;
    logic [SCNT_W-1:0]      slot_reg;
    logic [ACT_W-1:0]       cursor_reg;
    logic [ACT_W-1:0]       end_reg;
    logic [BLK_W-1:0]       cur_reg;
    logic [BLK_W-1:0]       last_reg;
    logic [BLK_W-1:0]       first_reg;
    logic [BCNT_W-1:0]      steps_reg;
    logic [LEN_W-1:0]       len_reg;
    logic [LEN_W-1:0]       want_reg;
    logic [LEN_W-1:0]       done_reg;
    logic                   capped_reg;
    logic [2:0]             status_reg;
    logic [LEN_W-1:0]       size_reg;
    logic [LEN_W-1:0]       added_reg;
    logic [FIRST_W-1:0]     rfirst_reg;
    logic                   rsp_valid_reg;
    rsp_t                   rsp_reg;

    logic                   link_we;
    logic [BLK_W-1:0]       link_waddr;
    logic [BLK_W-1:0]       link_wdata;
    logic [BLK_W-1:0]       link_raddr;
    logic [BLK_W-1:0]       link_rdata;
    logic                   dir_we;
    dir_t                   dir_wdata;
    dir_t                   dir_rdata;

    logic [ACT_W-1:0]       act_n;
    logic [ACT_W-1:0]       tb_ext;
    logic [ACT_W-1:0]       db_ext;
    logic                   slot_end;
    logic                   slot_used;
    logic                   nx_on;
    logic [LEN_W-1:0]       step_add;
    logic [LEN_W-1:0]       done_new;
    logic [LEN_W-1:0]       init_done;
    logic [LEN_W-1:0]       used_part;
    logic [LEN_W-1:0]       room;
    logic                   out_free;
    logic                   walk_stop;

    function automatic logic [NAME_W-1:0] clean_name(input logic [NAME_W-1:0] x);
        logic [NAME_W-1:0] r;
        logic              stop;
        r    = '0;
        stop = 1'b0;
        for (int k = NAME_CHARS - 1; k >= 0; k--)
        begin
            if (x[8*k +: 8] == 8'd0)
            begin
                stop = 1'b1;
            end
            if (!stop)
            begin
                r[8*k +: 8] = x[8*k +: 8];
            end
        end
        return r;
    endfunction

    function automatic logic [FIRST_W-1:0] to_first(input logic [BLK_W-1:0] b);
        logic [BLK_W+FIRST_W-1:0] w;
        w = {{FIRST_W{1'b0}}, b};
        return w[FIRST_W-1:0];
    endfunction

    function automatic logic [LEN_W-1:0] min_len(input logic [LEN_W-1:0] a,
                                                  input logic [LEN_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    assign tb_ext    = ACT_W'(TABLE_BLOCKS);
    assign db_ext    = ACT_W'(disk_blocks_reg);
    assign act_n     = (db_ext > tb_ext) ? tb_ext : db_ext;
    assign slot_end  = (slot_reg == SCNT_W'(DIR_SLOTS));
    assign slot_used = used_reg[slot_reg[SLOT_W-1:0]];
    assign nx_on     = (link_rdata != LINK_END) && (link_rdata != LINK_FREE)
                       && ({1'b0, link_rdata} < (BLK_W+1)'(TABLE_BLOCKS));
    assign step_add  = min_len(BB, want_reg - done_reg);
    assign done_new  = done_reg + step_add;
    assign used_part = len_reg & (BB - LEN_W'(1));
    assign room      = BB - used_part;
    assign init_done = (len_reg == '0) ? min_len(BB, want_reg) :
                       (used_part != '0) ? min_len(room, want_reg) : '0;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign walk_stop = (steps_reg == BCNT_W'(TABLE_BLOCKS))
                       || ({1'b0, cur_reg} >= (BLK_W+1)'(TABLE_BLOCKS));

    assign cfg_ready = 1'b1;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        link_we    = 1'b0;
        link_waddr = cur_reg;
        link_wdata = LINK_FREE;
        link_raddr = cur_reg;
        dir_we     = 1'b0;
        dir_wdata  = '{name: name_reg, len: done_new, first: first_reg};
        case (state_reg)
            S_CLEAR:
            begin
                link_we    = 1'b1;
                link_waddr = cursor_reg[BLK_W-1:0];
                link_wdata = (cursor_reg < ACT_W'(FIRST_DATA_BLOCK)) ? LINK_END : LINK_FREE;
            end
            S_FREE_RD:
            begin
                link_raddr = cursor_reg[BLK_W-1:0];
            end
            S_FREE_CHK:
            begin
                if (link_rdata == LINK_FREE)
                begin
                    link_we = 1'b1;
                    if (op_reg == REQ_GROW)
                    begin
                        link_waddr = last_reg;
                        link_wdata = cursor_reg[BLK_W-1:0];
                    end
                    else
                    begin
                        link_waddr = cursor_reg[BLK_W-1:0];
                        link_wdata = LINK_END;
                        dir_we     = 1'b1;
                        dir_wdata  = '{name: name_reg, len: '0,
                                       first: cursor_reg[BLK_W-1:0]};
                    end
                end
            end
            S_GROW_END:
            begin
                link_we    = 1'b1;
                link_waddr = last_reg;
                link_wdata = LINK_END;
            end
            S_WALK_CHK:
            begin
                link_we = (op_reg == REQ_DELETE);
            end
            S_GROW_FIN:
            begin
                dir_we    = 1'b1;
                dir_wdata = '{name: name_reg, len: len_reg + done_reg, first: first_reg};
            end
            default:
            begin
            end
        endcase
    end

    fcdm_ram #(
        .WIDTH(BLK_W),
        .DEPTH(TABLE_BLOCKS)
    ) u_link_ram (
        .clk  (clk),
        .we   (link_we),
        .waddr(link_waddr),
        .wdata(link_wdata),
        .raddr(link_raddr),
        .rdata(link_rdata)
    );

    fcdm_ram #(
        .WIDTH($bits(dir_t)),
        .DEPTH(DIR_SLOTS)
    ) u_dir_ram (
        .clk  (clk),
        .we   (dir_we),
        .waddr(slot_reg[SLOT_W-1:0]),
        .wdata(dir_wdata),
        .raddr(slot_reg[SLOT_W-1:0]),
        .rdata(dir_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            fmt_reg         <= 1'b0;
            disk_blocks_reg <= DISK_W'(1024);
            mounted_reg     <= 1'b0;
            used_reg        <= '0;
            cursor_reg      <= '0;
            end_reg         <= ACT_W'(TABLE_BLOCKS);
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_DISK_BLOCKS: disk_blocks_reg <= cfg_data;
                    CFG_MOUNTED:     mounted_reg     <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
            if (rsp_valid_reg && !rsp_stall && (state_reg != S_DONE))
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    if (cursor_reg + ACT_W'(1) >= end_reg)
                    begin
                        state_reg <= fmt_reg ? S_DONE : S_IDLE;
                    end
                    cursor_reg <= cursor_reg + ACT_W'(1);
                end
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        op_reg     <= req.req_type;
                        name_reg   <= clean_name(req.file_name);
                        add_reg    <= req.add_bytes;
                        status_reg <= ST_ERR;
                        size_reg   <= '0;
                        added_reg  <= '0;
                        rfirst_reg <= '0;
                        slot_reg   <= '0;
                        state_reg  <= S_DONE;
                        if (req.req_type == REQ_FORMAT)
                        begin
                            if (!mounted_reg)
                            begin
                                used_reg   <= '0;
                                status_reg <= ST_OK;
                                fmt_reg    <= 1'b1;
                                cursor_reg <= '0;
                                end_reg    <= (act_n > ACT_W'(FIRST_DATA_BLOCK)) ?
                                              act_n : ACT_W'(FIRST_DATA_BLOCK);
                                state_reg  <= S_CLEAR;
                            end
                        end
                        else if (mounted_reg)
                        begin
                            case (req.req_type)
                                REQ_CREATE: state_reg <= S_SLOT_FREE;
                                REQ_DELETE: state_reg <= S_FIND_RD;
                                REQ_SIZE:   state_reg <= S_FIND_RD;
                                REQ_GROW:   state_reg <= S_FIND_RD;
                                default:    state_reg <= S_DONE;
                            endcase
                        end
                    end
                end
                S_SLOT_FREE:
                begin
                    if (slot_end)
                    begin
                        status_reg <= ST_DIR_FULL;
                        state_reg  <= S_DONE;
                    end
                    else if (!slot_used)
                    begin
                        cursor_reg <= '0;
                        state_reg  <= S_FREE_RD;
                    end
                    else
                    begin
                        slot_reg <= slot_reg + SCNT_W'(1);
                    end
                end
                S_FREE_RD:
                begin
                    if (cursor_reg >= act_n)
                    begin
                        if (op_reg == REQ_GROW)
                        begin
                            status_reg <= (done_reg == '0) ? ST_DISK_FULL : ST_PARTIAL;
                            state_reg  <= S_GROW_FIN;
                        end
                        else
                        begin
                            status_reg <= ST_DISK_FULL;
                            state_reg  <= S_DONE;
                        end
                    end
                    else
                    begin
                        state_reg <= S_FREE_CHK;
                    end
                end
                S_FREE_CHK:
                begin
                    if (link_rdata == LINK_FREE)
                    begin
                        if (op_reg == REQ_GROW)
                        begin
                            last_reg  <= cursor_reg[BLK_W-1:0];
                            state_reg <= S_GROW_END;
                        end
                        else
                        begin
                            used_reg[slot_reg[SLOT_W-1:0]] <= 1'b1;
                            status_reg <= ST_OK;
                            rfirst_reg <= to_first(cursor_reg[BLK_W-1:0]);
                            state_reg  <= S_DONE;
                        end
                    end
                    else
                    begin
                        cursor_reg <= cursor_reg + ACT_W'(1);
                        state_reg  <= S_FREE_RD;
                    end
                end
                S_GROW_END:
                begin
                    done_reg   <= done_new;
                    cursor_reg <= cursor_reg + ACT_W'(1);
                    state_reg  <= (done_new < want_reg) ? S_FREE_RD : S_GROW_FIN;
                end
                S_FIND_RD:
                begin
                    state_reg <= slot_end ? S_DONE : S_FIND_CHK;
                end
                S_FIND_CHK:
                begin
                    if (slot_used && (dir_rdata.name == name_reg))
                    begin
                        first_reg <= dir_rdata.first;
                        cur_reg   <= dir_rdata.first;
                        steps_reg <= '0;
                        len_reg   <= min_len(dir_rdata.len, LMAX);
                        want_reg  <= min_len(add_reg, LMAX - min_len(dir_rdata.len, LMAX));
                        capped_reg <= (min_len(add_reg, LMAX - min_len(dir_rdata.len, LMAX))
                                       < add_reg);
                        case (op_reg)
                            REQ_SIZE:
                            begin
                                status_reg <= ST_OK;
                                size_reg   <= dir_rdata.len;
                                rfirst_reg <= to_first(dir_rdata.first);
                                state_reg  <= S_DONE;
                            end
                            REQ_DELETE:
                            begin
                                used_reg[slot_reg[SLOT_W-1:0]] <= 1'b0;
                                state_reg <= S_WALK_RD;
                            end
                            default:
                            begin
                                state_reg <= S_WALK_RD;
                            end
                        endcase
                    end
                    else
                    begin
                        slot_reg  <= slot_reg + SCNT_W'(1);
                        state_reg <= S_FIND_RD;
                    end
                end
                S_WALK_RD:
                begin
                    if (walk_stop)
                    begin
                        last_reg   <= cur_reg;
                        status_reg <= ST_OK;
                        state_reg  <= (op_reg == REQ_GROW) ? S_GROW_START : S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_WALK_CHK;
                    end
                end
                S_WALK_CHK:
                begin
                    if (!nx_on)
                    begin
                        last_reg   <= cur_reg;
                        status_reg <= ST_OK;
                        state_reg  <= (op_reg == REQ_GROW) ? S_GROW_START : S_DONE;
                    end
                    else
                    begin
                        cur_reg   <= link_rdata;
                        steps_reg <= steps_reg + BCNT_W'(1);
                        state_reg <= S_WALK_RD;
                    end
                end
                S_GROW_START:
                begin
                    done_reg   <= init_done;
                    status_reg <= capped_reg ? ST_PARTIAL : ST_OK;
                    cursor_reg <= ACT_W'(FIRST_DATA_BLOCK);
                    state_reg  <= (init_done < want_reg) ? S_FREE_RD : S_GROW_FIN;
                end
                S_GROW_FIN:
                begin
                    size_reg   <= len_reg + done_reg;
                    added_reg  <= done_reg;
                    rfirst_reg <= to_first(first_reg);
                    state_reg  <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        rsp_valid_reg       <= 1'b1;
                        rsp_reg.status      <= status_reg;
                        rsp_reg.file_size   <= size_reg;
                        rsp_reg.bytes_added <= added_reg;
                        rsp_reg.first_block <= rfirst_reg;
                        fmt_reg             <= 1'b0;
                        state_reg           <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: design/fcdm_ram.sv
// ----------------------------------------------------------------------------
// fcdm_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module fcdm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
